>>> design/rsop_pkg.sv
// Shared types, constants and saturation helpers for the rate sum-of-products block.
package rsop_pkg;

  localparam int VALUE_W       = 32;
  localparam int VALUE_INDEX_W = 9;
  localparam int NUMBER_W      = 11;
  localparam int OUT_INDEX_W   = 10;
  localparam int MOD_W         = 3;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_FACTOR = 1'b1;

  localparam logic [MOD_W-1:0] MOD_NEW_TERM  = 3'b100;
  localparam logic [MOD_W-1:0] MOD_ONE_MINUS = 3'b001;
  localparam logic [MOD_W-1:0] MOD_RECIP     = 3'b010;

  localparam logic [VALUE_W-1:0] FX_MAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] FX_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INDEX,
    ST_READ,
    ST_MODIFY,
    ST_DIV,
    ST_MUL,
    ST_MAG,
    ST_SAT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               ovf;
  } sat_t;

  // Clamps a 33-bit signed sum to the 32-bit range.
  function automatic sat_t sat_sum(input logic [VALUE_W:0] v);
    sat_t r;
    r.ovf   = v[VALUE_W] ^ v[VALUE_W-1];
    r.value = r.ovf ? (v[VALUE_W] ? FX_MIN : FX_MAX) : v[VALUE_W-1:0];
    return r;
  endfunction

  // Applies a sign to a magnitude and clamps it to the 32-bit range.
  function automatic sat_t sat_mag(input logic [63:0] mag, input logic neg);
    sat_t r;
    if (neg) begin
      r.ovf   = mag > 64'h0000_0000_8000_0000;
      r.value = r.ovf ? FX_MIN : 32'd0 - mag[VALUE_W-1:0];
    end else begin
      r.ovf   = mag > 64'h0000_0000_7FFF_FFFF;
      r.value = r.ovf ? FX_MAX : mag[VALUE_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/rsop_index.sv
// Reduces the one-based table index, row and column to zero-based values by a compare-subtract ladder.
module rsop_index #(
  parameter int TABLE_DEPTH = 256,
  parameter int INDEX_LIMIT = 1024,
  localparam int SLOT_AW = $clog2(TABLE_DEPTH)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [rsop_pkg::VALUE_INDEX_W-1:0] value_index_i,
  input  logic [rsop_pkg::NUMBER_W-1:0]      row_number_i,
  input  logic [rsop_pkg::NUMBER_W-1:0]      col_number_i,
  output logic [SLOT_AW-1:0]                 slot_o,
  output logic [rsop_pkg::OUT_INDEX_W-1:0]   row_index_o,
  output logic [rsop_pkg::OUT_INDEX_W-1:0]   col_index_o,
  output rsop_pkg::unit_status_t             status_o
);
  import rsop_pkg::*;

  localparam int SLOT_MAX   = 2 ** VALUE_INDEX_W - 1 + TABLE_DEPTH - 1;
  localparam int SLOT_SW    = $clog2(SLOT_MAX + 1);
  localparam int SLOT_STEPS = $clog2(SLOT_MAX / TABLE_DEPTH + 1);
  localparam int NUM_MAX    = 2 ** NUMBER_W - 1 + INDEX_LIMIT - 1;
  localparam int NUM_SW     = $clog2(NUM_MAX + 1);
  localparam int NUM_STEPS  = $clog2(NUM_MAX / INDEX_LIMIT + 1);
  localparam int RED_STEPS  = (SLOT_STEPS > NUM_STEPS) ? SLOT_STEPS : NUM_STEPS;
  localparam int CNT_W      = $clog2(RED_STEPS + 1);

  localparam logic [SLOT_SW-1:0] SLOT_TOP = SLOT_SW'(TABLE_DEPTH * (2 ** (SLOT_STEPS - 1)));
  localparam logic [NUM_SW-1:0]  NUM_TOP  = NUM_SW'(INDEX_LIMIT * (2 ** (NUM_STEPS - 1)));

  logic [SLOT_SW-1:0] slot_q, slot_d, slot_sub_q, slot_sub_d;
  logic [NUM_SW-1:0]  row_q, row_d, col_q, col_d, num_sub_q, num_sub_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;

  always_comb begin
    slot_d     = slot_q;
    slot_sub_d = slot_sub_q;
    row_d      = row_q;
    col_d      = col_q;
    num_sub_d  = num_sub_q;
    cnt_d      = cnt_q;
    busy_d     = busy_q;
    done_d     = 1'b0;
    if (start_i) begin
      slot_d     = SLOT_SW'(value_index_i) + SLOT_SW'(TABLE_DEPTH - 1);
      slot_sub_d = SLOT_TOP;
      row_d      = NUM_SW'(row_number_i) + NUM_SW'(INDEX_LIMIT - 1);
      col_d      = NUM_SW'(col_number_i) + NUM_SW'(INDEX_LIMIT - 1);
      num_sub_d  = NUM_TOP;
      cnt_d      = CNT_W'(RED_STEPS);
      busy_d     = 1'b1;
    end else if (busy_q) begin
      if (cnt_q <= CNT_W'(SLOT_STEPS)) begin
        if (slot_q >= slot_sub_q) begin
          slot_d = slot_q - slot_sub_q;
        end
        slot_sub_d = slot_sub_q >> 1;
      end
      if (cnt_q <= CNT_W'(NUM_STEPS)) begin
        if (row_q >= num_sub_q) begin
          row_d = row_q - num_sub_q;
        end
        if (col_q >= num_sub_q) begin
          col_d = col_q - num_sub_q;
        end
        num_sub_d = num_sub_q >> 1;
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    slot_sub_q <= slot_sub_d;
    row_q      <= row_d;
    col_q      <= col_d;
    num_sub_q  <= num_sub_d;
  end

  assign slot_o      = slot_q[SLOT_AW-1:0];
  assign row_index_o = row_q[OUT_INDEX_W-1:0];
  assign col_index_o = col_q[OUT_INDEX_W-1:0];
  assign status_o    = '{busy: busy_q, done: done_q};

endmodule

>>> design/rsop_div.sv
// Bit-serial restoring divider that forms the fixed-point reciprocal quotient.
module rsop_div #(
  parameter int FRAC_BITS = 16,
  localparam int QW = 2 * FRAC_BITS + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rsop_pkg::VALUE_W-1:0]  divisor_i,
  output logic [QW-1:0]                 quotient_o,
  output rsop_pkg::unit_status_t        status_o
);
  import rsop_pkg::*;

  localparam int CW = $clog2(QW);

  logic [CW-1:0]      cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [VALUE_W:0]   rem_q, rem_d;
  logic [QW-1:0]      quo_q, quo_d;
  logic [VALUE_W-1:0] dvs_q, dvs_d;
  logic [VALUE_W:0]   trial;

  // The dividend is a single one at bit 2*FRAC_BITS, so it enters on the first step only.
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    trial  = {rem_q[VALUE_W-1:0], (cnt_q == CW'(QW - 1))};
    if (start_i) begin
      cnt_d  = CW'(QW - 1);
      busy_d = 1'b1;
      rem_d  = '0;
      quo_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[QW-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign status_o   = '{busy: busy_q, done: done_q};

endmodule

>>> design/rate_sum_of_products_core.sv
// Top level of the rate sum-of-products block: sequencer, value table, multiplier and accumulators.
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+------------------------------------------
//   input   | in        | in_valid_i / in_stall_o   | operation, value_index, value_data,
//           |           |                           | modifier, row_number, col_number, last
//   output  | out       | out_valid_o / out_stall_i | row_index, col_index, rate_value, overflow
//
// A load word passes the index ladder and then writes the table; a factor word passes the index ladder,
// the registered table read and the three-stage multiply and saturate path.
// A reciprocal factor also passes through the bit-serial divider.
// Reset clears the sequencer, the sum to zero, the product to one and the overflow flag.
// A finished word waits in the output register; the next input word is taken meanwhile,
// and a last factor waits to emit until that register is free.
module rate_sum_of_products_core #(
  parameter int TABLE_DEPTH = 256,
  parameter int INDEX_LIMIT = 1024,
  parameter int FRAC_BITS   = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               operation_i,
  input  logic [rsop_pkg::VALUE_INDEX_W-1:0] value_index_i,
  input  logic signed [rsop_pkg::VALUE_W-1:0] value_data_i,
  input  logic [rsop_pkg::MOD_W-1:0]         modifier_i,
  input  logic [rsop_pkg::NUMBER_W-1:0]      row_number_i,
  input  logic [rsop_pkg::NUMBER_W-1:0]      col_number_i,
  input  logic                               last_factor_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [rsop_pkg::OUT_INDEX_W-1:0]   row_index_o,
  output logic [rsop_pkg::OUT_INDEX_W-1:0]   col_index_o,
  output logic signed [rsop_pkg::VALUE_W-1:0] rate_value_o,
  output logic                               overflow_o
);
  import rsop_pkg::*;

  localparam int SLOT_AW = $clog2(TABLE_DEPTH);
  localparam int QW      = 2 * FRAC_BITS + 1;
  localparam logic [VALUE_W-1:0] FX_ONE = VALUE_W'(2 ** FRAC_BITS);

  state_e state_q, state_d;

  logic                   op_q, op_d, last_q, last_d;
  logic [MOD_W-1:0]       mod_q, mod_d;
  logic [VALUE_W-1:0]     data_q, data_d;
  logic [VALUE_W-1:0]     sum_q, sum_d, prod_q, prod_d, x_q, x_d;
  logic                   ovf_q, ovf_d, x_neg_q, x_neg_d, prod_neg_q, prod_neg_d;
  logic signed [63:0]     wide_q, wide_d;
  logic [63:0]            mag_q, mag_d;
  logic                   out_valid_q, out_valid_d, out_ovf_q, out_ovf_d;
  logic [OUT_INDEX_W-1:0] out_row_q, out_row_d, out_col_q, out_col_d;
  logic [VALUE_W-1:0]     out_rate_q, out_rate_d;

  logic                   accept, idx_start, div_start, mem_we;
  logic [SLOT_AW-1:0]     slot;
  logic [OUT_INDEX_W-1:0] idx_row, idx_col;
  unit_status_t           idx_status, div_status;
  logic [VALUE_W-1:0]     div_divisor;
  logic [QW-1:0]          quotient;
  logic [VALUE_W-1:0]     rdata_q;
  logic [VALUE_W-1:0]     table_mem [TABLE_DEPTH];
  sat_t                   s_term, s_mod, s_div, s_prod, s_total;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign idx_start  = accept;
  assign div_divisor = rdata_q[VALUE_W-1] ? VALUE_W'(0) - rdata_q : rdata_q;

  rsop_index #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .INDEX_LIMIT(INDEX_LIMIT)
  ) u_index (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (idx_start),
    .value_index_i(value_index_i),
    .row_number_i (row_number_i),
    .col_number_i (col_number_i),
    .slot_o       (slot),
    .row_index_o  (idx_row),
    .col_index_o  (idx_col),
    .status_o     (idx_status)
  );

  rsop_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (div_divisor),
    .quotient_o(quotient),
    .status_o  (div_status)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[slot] <= data_q;
    end
    rdata_q <= table_mem[slot];
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    last_d      = last_q;
    mod_d       = mod_q;
    data_d      = data_q;
    sum_d       = sum_q;
    prod_d      = prod_q;
    x_d         = x_q;
    ovf_d       = ovf_q;
    x_neg_d     = x_neg_q;
    prod_neg_d  = prod_neg_q;
    wide_d      = wide_q;
    mag_d       = mag_q;
    out_valid_d = out_valid_q;
    out_ovf_d   = out_ovf_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_rate_d  = out_rate_q;
    div_start   = 1'b0;
    mem_we      = 1'b0;
    s_term      = sat_sum({sum_q[VALUE_W-1], sum_q} + {prod_q[VALUE_W-1], prod_q});
    s_mod       = sat_sum({1'b0, FX_ONE} - {rdata_q[VALUE_W-1], rdata_q});
    s_div       = sat_mag(64'(quotient), x_neg_q);
    s_prod      = sat_mag(mag_q, prod_neg_q);
    s_total     = s_term;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d    = operation_i;
          last_d  = last_factor_i;
          mod_d   = modifier_i;
          data_d  = value_data_i;
          state_d = ST_INDEX;
        end
      end
      ST_INDEX: begin
        if (idx_status.done) begin
          if (op_q == OP_LOAD) begin
            mem_we  = 1'b1;
            state_d = ST_IDLE;
          end else if (op_q == OP_FACTOR) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_MODIFY;
      end
      ST_MODIFY: begin
        if ((mod_q & MOD_NEW_TERM) != '0) begin
          sum_d  = s_term.value;
          ovf_d  = ovf_d | s_term.ovf;
          prod_d = FX_ONE;
        end
        x_neg_d = rdata_q[VALUE_W-1];
        state_d = ST_MUL;
        if ((mod_q & MOD_ONE_MINUS) != '0) begin
          x_d   = s_mod.value;
          ovf_d = ovf_d | s_mod.ovf;
        end else if ((mod_q & MOD_RECIP) != '0) begin
          if (rdata_q == '0) begin
            x_d   = FX_MAX;
            ovf_d = 1'b1;
          end else begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end else begin
          x_d = rdata_q;
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          x_d     = s_div.value;
          ovf_d   = ovf_q | s_div.ovf;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        wide_d  = $signed(prod_q) * $signed(x_q);
        state_d = ST_MAG;
      end
      ST_MAG: begin
        prod_neg_d = wide_q[63];
        mag_d      = (wide_q[63] ? 64'd0 - wide_q : wide_q) >> FRAC_BITS;
        state_d    = ST_SAT;
      end
      ST_SAT: begin
        prod_d  = s_prod.value;
        ovf_d   = ovf_q | s_prod.ovf;
        state_d = last_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_row_d   = idx_row;
          out_col_d   = idx_col;
          out_rate_d  = s_total.value;
          out_ovf_d   = ovf_q | s_total.ovf;
          sum_d       = '0;
          prod_d      = FX_ONE;
          ovf_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      prod_q      <= FX_ONE;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      op_q        <= OP_LOAD;
      last_q      <= 1'b0;
      mod_q       <= '0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      prod_q      <= prod_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      op_q        <= op_d;
      last_q      <= last_d;
      mod_q       <= mod_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    x_q        <= x_d;
    x_neg_q    <= x_neg_d;
    prod_neg_q <= prod_neg_d;
    wide_q     <= wide_d;
    mag_q      <= mag_d;
    out_ovf_q  <= out_ovf_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_rate_q <= out_rate_d;
  end

  assign out_valid_o  = out_valid_q;
  assign row_index_o  = out_row_q;
  assign col_index_o  = out_col_q;
  assign rate_value_o = out_rate_q;
  assign overflow_o   = out_ovf_q;

  a_idx_done_in_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_status.done |-> state_q == ST_INDEX)
    else $error("Index ladder finished outside the index state.");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_status.done |-> state_q == ST_DIV)
    else $error("Divider finished outside the divide state.");

  a_div_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> (div_status.busy || div_status.done))
    else $error("Sequencer waits on an idle divider.");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && (!out_valid_q || !out_stall_i))
      |=> (out_valid_q && sum_q == '0 && prod_q == FX_ONE && !ovf_q))
    else $error("Emitted word did not restart the accumulators.");

endmodule
